### rtl/core/ehf_pkg.sv
// Shared constants and types for the edge sensing hole fill block.
`timescale 1ns / 1ps
`default_nettype none
package ehf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 512;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = COL_W + ROW_W;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int DIM_W      = COL_W + 1;
  localparam int HDIM_W     = ROW_W + 1;
  localparam int CNT_W      = 20;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_RUN   = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;

  // One stored pixel: known at sweep start, filled during this sweep, value.
  typedef struct packed {
    logic       known;
    logic       filled;
    logic [7:0] value;
  } px_word_t;

  localparam int WORD_W = $bits(px_word_t);

  // Neighbor values as seen at sweep start: left, right, top, bottom.
  typedef struct packed {
    logic [3:0]      known;
    logic [3:0][7:0] value;
  } nbr_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] value;
  } fill_res_t;

endpackage
`default_nettype wire

### rtl/core/ehf_ram.sv
// Generic simple dual port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module ehf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/core/ehf_fill_calc.sv
// Edge sensing fill value from four neighbors; half-even rounding except on corner pairs.
`timescale 1ns / 1ps
`default_nettype none
module ehf_fill_calc (
  input  wire ehf_pkg::nbr_t     nbr,
  output ehf_pkg::fill_res_t     res
);
  import ehf_pkg::*;

  logic [7:0] l, r, t, b;
  logic [8:0] lr, tb, q2lr, q2tb, sum_any;
  logic [9:0] s4;
  logic [7:0] q4;
  logic [2:0] n;

  assign l = nbr.known[3] ? nbr.value[3] : 8'd0;
  assign r = nbr.known[2] ? nbr.value[2] : 8'd0;
  assign t = nbr.known[1] ? nbr.value[1] : 8'd0;
  assign b = nbr.known[0] ? nbr.value[0] : 8'd0;

  assign lr = {1'b0, l} + {1'b0, r};
  assign tb = {1'b0, t} + {1'b0, b};
  assign s4 = {1'b0, lr} + {1'b0, tb};
  assign n  = 3'($countones(nbr.known));

  // Round half to even on pair and quad means.
  assign q2lr = {1'b0, lr[8:1]} + 9'(lr[0] & lr[1]);
  assign q2tb = {1'b0, tb[8:1]} + 9'(tb[0] & tb[1]);
  assign q4   = s4[9:2] + 8'((s4[1] & s4[0]) | (s4[1] & ~s4[0] & s4[2]));
  assign sum_any = lr + tb;

  always_comb begin
    res.hit   = 1'b1;
    res.value = 8'd0;
    priority if (n == 3'd4) begin
      priority if (lr < tb) res.value = q2lr[7:0];
      else if (lr > tb)     res.value = q2tb[7:0];
      else                  res.value = q4;
    end else if (nbr.known[3] && nbr.known[2]) begin
      res.value = q2lr[7:0];
    end else if (nbr.known[1] && nbr.known[0]) begin
      res.value = q2tb[7:0];
    end else if (n == 3'd2) begin
      res.value = sum_any[8:1];
    end else begin
      res.hit = 1'b0;
    end
  end
endmodule
`default_nettype wire

### rtl/core/iterative_edge_sensing_hole_fill_top.sv
// Top level: pixel store, fill sequencer and handshakes.
//
//  channel | ports                                    | direction
//  --------+------------------------------------------+----------
//  in      | in_valid/in_ready, in_req_type..known    | request
//  out     | out_valid/out_ready, out_read_value..    | response
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data | register write
//
// A write waits in S_RESP for out_ready; a read in bounds passes S_RD_WAIT
// first. A run reads each pixel in each sweep and, for an unknown one, its
// four neighbors before S_SW_CALC; after each sweep a commit pass reads
// every pixel again, all set by the single read port of the pixel store.
// After reset a clearing pass over all 524288 (MAX_WIDTH*MAX_HEIGHT) words
// zeroes the store; no request is taken meanwhile, register writes are.
// One transaction at a time: in_ready drops until the response is taken.
`timescale 1ns / 1ps
`default_nettype none
module iterative_edge_sensing_hole_fill_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [9:0]  in_pixel_col,
  input  wire logic [8:0]  in_pixel_row,
  input  wire logic [7:0]  in_write_value,
  input  wire logic        in_write_known,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_read_value,
  output logic             out_read_known,
  output logic [19:0]      out_sweeps_done,
  output logic [19:0]      out_holes_left,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [10:0] cfg_data
);
  import ehf_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD_WAIT, S_RESP,
    S_SW_ISS, S_SW_CAP, S_SW_CALC, S_CM_ISS, S_CM_CAP
  } state_t;

  state_t            state_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [COL_W-1:0]  x_r;
  logic [ROW_W-1:0]  y_r;
  logic [2:0]        step_r;
  nbr_t              nbr_r;
  logic              progress_r;
  logic [CNT_W-1:0]  sweeps_r, holes_r, cnt_r;
  logic [7:0]        rd_value_r;
  logic              rd_known_r, out_valid_r;
  logic [10:0]       width_r;
  logic [9:0]        height_r;

  logic [DIM_W-1:0]  w_eff;
  logic [HDIM_W-1:0] h_eff;
  logic              in_acc, in_bounds, last_x, last_y;
  logic [ADDR_W-1:0] in_addr, cur_addr, nb_addr;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  px_word_t          ram_wdata, ram_rdata;
  fill_res_t         fill;

  // Clamp active size to 1..MAX.
  assign w_eff = (width_r == 11'd0) ? DIM_W'(1) :
                 (width_r > 11'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : DIM_W'(width_r);
  assign h_eff = (height_r == 10'd0) ? HDIM_W'(1) :
                 (height_r > 10'(MAX_HEIGHT)) ? HDIM_W'(MAX_HEIGHT) : HDIM_W'(height_r);

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign in_bounds = (DIM_W'(in_pixel_col) < w_eff) && (HDIM_W'(in_pixel_row) < h_eff);
  assign in_addr   = {ROW_W'(in_pixel_row), COL_W'(in_pixel_col)};
  assign cur_addr  = {y_r, x_r};
  assign last_x    = ({1'b0, x_r} + DIM_W'(1)) == w_eff;
  assign last_y    = ({1'b0, y_r} + HDIM_W'(1)) == h_eff;

  // Neighbor beyond the image clamps onto the pixel itself (unknown).
  always_comb begin
    nb_addr = cur_addr;
    unique case (step_r)
      3'd1: if (x_r != '0) nb_addr = {y_r, x_r - COL_W'(1)};
      3'd2: if (!last_x)   nb_addr = {y_r, x_r + COL_W'(1)};
      3'd3: if (y_r != '0) nb_addr = {y_r - ROW_W'(1), x_r};
      3'd4: if (!last_y)   nb_addr = {y_r + ROW_W'(1), x_r};
      default: nb_addr = cur_addr;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_addr;
    ram_wdata = '0;
    ram_raddr = cur_addr;
    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
      end
      S_IDLE: begin
        ram_raddr = in_addr;
        ram_we    = in_acc && (in_req_type == REQ_WRITE) && in_bounds;
        ram_waddr = in_addr;
        ram_wdata = '{known: in_write_known, filled: 1'b0, value: in_write_value};
      end
      S_SW_ISS: ram_raddr = nb_addr;
      S_SW_CALC: begin
        ram_we    = fill.hit;
        ram_wdata = '{known: 1'b0, filled: 1'b1, value: fill.value};
      end
      S_CM_CAP: begin
        // Promote this sweep's fills to known.
        ram_we    = ram_rdata.filled;
        ram_wdata = '{known: 1'b1, filled: 1'b0, value: ram_rdata.value};
      end
      default: ram_raddr = cur_addr;
    endcase
  end

  ehf_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ehf_fill_calc u_calc (
    .nbr (nbr_r),
    .res (fill)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      x_r         <= '0;
      y_r         <= '0;
      step_r      <= '0;
      progress_r  <= 1'b0;
      sweeps_r    <= '0;
      holes_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      rd_value_r  <= '0;
      rd_known_r  <= 1'b0;
      width_r     <= 11'd640;
      height_r    <= 10'd480;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_WIDTH)  width_r  <= cfg_data;
        if (cfg_index == CFG_HEIGHT) height_r <= cfg_data[9:0];
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + ADDR_W'(1);
          if (clr_addr_r == '1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            rd_value_r <= '0;
            rd_known_r <= 1'b0;
            priority if (in_req_type == REQ_RUN) begin
              sweeps_r   <= '0;
              progress_r <= 1'b0;
              x_r        <= '0;
              y_r        <= '0;
              step_r     <= '0;
              state_r    <= S_SW_ISS;
            end else if (in_req_type == REQ_READ && in_bounds) begin
              state_r <= S_RD_WAIT;
            end else begin
              out_valid_r <= 1'b1;
              state_r     <= S_RESP;
            end
          end
        end
        S_RD_WAIT: begin
          rd_value_r  <= ram_rdata.value;
          rd_known_r  <= ram_rdata.known;
          out_valid_r <= 1'b1;
          state_r     <= S_RESP;
        end
        S_RESP: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        S_SW_ISS: state_r <= S_SW_CAP;
        S_SW_CAP: begin
          if (step_r == 3'd0) begin
            if (ram_rdata.known) begin
              // Known pixel: advance to the next one.
              step_r <= '0;
              if (last_x) begin
                x_r <= '0;
                if (last_y) begin
                  y_r     <= '0;
                  cnt_r   <= '0;
                  state_r <= S_CM_ISS;
                end else begin
                  y_r     <= y_r + ROW_W'(1);
                  state_r <= S_SW_ISS;
                end
              end else begin
                x_r     <= x_r + COL_W'(1);
                state_r <= S_SW_ISS;
              end
            end else begin
              step_r  <= 3'd1;
              state_r <= S_SW_ISS;
            end
          end else begin
            nbr_r.known[2'(3'd4 - step_r)] <= ram_rdata.known;
            nbr_r.value[2'(3'd4 - step_r)] <= ram_rdata.value;
            if (step_r == 3'd4) begin
              state_r <= S_SW_CALC;
            end else begin
              step_r  <= step_r + 3'd1;
              state_r <= S_SW_ISS;
            end
          end
        end
        S_SW_CALC: begin
          if (fill.hit) progress_r <= 1'b1;
          step_r <= '0;
          if (last_x) begin
            x_r <= '0;
            if (last_y) begin
              y_r     <= '0;
              cnt_r   <= '0;
              state_r <= S_CM_ISS;
            end else begin
              y_r     <= y_r + ROW_W'(1);
              state_r <= S_SW_ISS;
            end
          end else begin
            x_r     <= x_r + COL_W'(1);
            state_r <= S_SW_ISS;
          end
        end
        S_CM_ISS: state_r <= S_CM_CAP;
        S_CM_CAP: begin
          // Count pixels still unknown after promotion.
          if (!(ram_rdata.known || ram_rdata.filled) && cnt_r != CNT_MAX) begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
          if (last_x) begin
            x_r <= '0;
            if (last_y) begin
              y_r <= '0;
              if (sweeps_r != CNT_MAX) sweeps_r <= sweeps_r + CNT_W'(1);
              if (progress_r) begin
                progress_r <= 1'b0;
                state_r    <= S_SW_ISS;
              end else begin
                holes_r <= (!(ram_rdata.known || ram_rdata.filled) && cnt_r != CNT_MAX)
                           ? cnt_r + CNT_W'(1) : cnt_r;
                out_valid_r <= 1'b1;
                state_r     <= S_RESP;
              end
            end else begin
              y_r     <= y_r + ROW_W'(1);
              state_r <= S_CM_ISS;
            end
          end else begin
            x_r     <= x_r + COL_W'(1);
            state_r <= S_CM_ISS;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = rd_value_r;
  assign out_read_known  = rd_known_r;
  assign out_sweeps_done = sweeps_r;
  assign out_holes_left  = holes_r;
endmodule
`default_nettype wire

### rtl/core/ehf_checker.sv
// Port-level assertions for the hole fill top level, bound to it.
`timescale 1ns / 1ps
`default_nettype none
module ehf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  out_read_value,
  input wire logic        out_read_known,
  input wire logic [19:0] out_sweeps_done,
  input wire logic [19:0] out_holes_left
);
  // Hold a stalled response.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_value) &&
      $stable(out_read_known) && $stable(out_sweeps_done) && $stable(out_holes_left))
    else $error("response changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("request taken with response pending");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("activity right after reset");
endmodule

bind iterative_edge_sensing_hole_fill_top ehf_checker u_ehf_checker (.*);
`default_nettype wire

### verif/tb.sv
// Self-checking testbench for the iterative edge sensing hole fill block.
`timescale 1ns / 1ps
module tb;
  import ehf_pkg::*;

  // Request and register codes the package leaves unnamed.
  localparam logic [1:0] REQ_NONE      = 2'd3;
  localparam logic [1:0] CFG_SPARE_LO  = 2'd2;
  localparam logic [1:0] CFG_SPARE_HI  = 2'd3;
  localparam int         ITEM_TARGET   = 750;
  localparam int         CYCLE_LIMIT   = 6_000_000;
  localparam int         SETTLE_CYCLES = 32;
  localparam int         EXP_DEPTH     = 16;

  typedef struct packed {
    logic [7:0]       value;
    logic             known;
    logic [CNT_W-1:0] sweeps;
    logic [CNT_W-1:0] holes;
  } resp_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_req_type;
  logic [9:0]        in_pixel_col;
  logic [8:0]        in_pixel_row;
  logic [7:0]        in_write_value;
  logic              in_write_known;
  logic              out_valid;
  logic              out_ready;
  logic [7:0]        out_read_value;
  logic              out_read_known;
  logic [19:0]       out_sweeps_done;
  logic [19:0]       out_holes_left;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [1:0]        cfg_index;
  logic [10:0]       cfg_data;

  iterative_edge_sensing_hole_fill_top dut (.*);

  // Shadow image: values, known flags and fills pending for this sweep.
  logic [7:0]       shadow_pix   [DEPTH];
  bit               shadow_known [DEPTH];
  bit               shadow_fill  [DEPTH];
  logic [DIM_W-1:0]  width_reg;
  logic [HDIM_W-1:0] height_reg;
  logic [CNT_W-1:0]  last_sweeps;
  logic [CNT_W-1:0]  last_holes;

  resp_t  exp_fifo [EXP_DEPTH];
  int     exp_wr;
  int     exp_rd;
  int     error_count;
  int     item_count;
  int     cycle_count;
  bit     idle_on;
  bit     hold_req;
  int     stall_left;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int eff_dim(int v, int maxv);
    if (v < 1) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int mean2_even(int s);
    int q;
    q = s >> 1;
    if ((s & 1) && (q & 1)) q++;
    return q;
  endfunction

  function automatic int mean4_even(int s);
    int q;
    int rem;
    q = s >> 2;
    rem = s & 3;
    if (rem > 2 || (rem == 2 && (q & 1))) q++;
    return q;
  endfunction

  // Fill value from neighbors known at sweep start; returns 0 if too few.
  function automatic bit fill_pixel(int x, int y, int w, int h, output int v);
    int  here;
    bit  hl, hr, ht, hb;
    int  l, r, t, b;
    here = y * MAX_WIDTH + x;
    hl = 0; hr = 0; ht = 0; hb = 0;
    l = 0; r = 0; t = 0; b = 0;
    v = 0;
    if (x > 0 && shadow_known[here-1]) begin hl = 1; l = shadow_pix[here-1]; end
    if (x + 1 < w && shadow_known[here+1]) begin hr = 1; r = shadow_pix[here+1]; end
    if (y > 0 && shadow_known[here-MAX_WIDTH]) begin
      ht = 1; t = shadow_pix[here-MAX_WIDTH];
    end
    if (y + 1 < h && shadow_known[here+MAX_WIDTH]) begin
      hb = 1; b = shadow_pix[here+MAX_WIDTH];
    end
    if (hl && hr && ht && hb) begin
      if (l + r < t + b) v = mean2_even(l + r);
      else if (l + r > t + b) v = mean2_even(t + b);
      else v = mean4_even(l + r + t + b);
    end else if (hl && hr) begin
      v = mean2_even(l + r);
    end else if (ht && hb) begin
      v = mean2_even(t + b);
    end else if (int'(hl) + int'(hr) + int'(ht) + int'(hb) == 2) begin
      v = (l + r + t + b) >> 1;
    end else begin
      return 0;
    end
    return 1;
  endfunction

  task automatic fill_image();
    int w, h, v, holes;
    bit progress;
    w = eff_dim(width_reg, MAX_WIDTH);
    h = eff_dim(height_reg, MAX_HEIGHT);
    last_sweeps = '0;
    do begin
      progress = 0;
      for (int y = 0; y < h; y++)
        for (int x = 0; x < w; x++)
          if (!shadow_known[y*MAX_WIDTH+x] && fill_pixel(x, y, w, h, v)) begin
            // value lands now; known waits for the sweep to end
            shadow_pix[y*MAX_WIDTH+x] = v[7:0];
            shadow_fill[y*MAX_WIDTH+x] = 1;
            progress = 1;
          end
      for (int y = 0; y < h; y++)
        for (int x = 0; x < w; x++)
          if (shadow_fill[y*MAX_WIDTH+x]) begin
            shadow_known[y*MAX_WIDTH+x] = 1;
            shadow_fill[y*MAX_WIDTH+x]  = 0;
          end
      if (last_sweeps != CNT_MAX) last_sweeps++;
    end while (progress);
    holes = 0;
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++)
        if (!shadow_known[y*MAX_WIDTH+x] && holes < int'(CNT_MAX)) holes++;
    last_holes = holes[CNT_W-1:0];
  endtask

  task automatic predict_req(logic [1:0] req, int col, int row, int val, bit kn,
                             output resp_t rsp);
    bit in_image;
    int idx;
    in_image = col < eff_dim(width_reg, MAX_WIDTH) && row < eff_dim(height_reg, MAX_HEIGHT);
    idx = row * MAX_WIDTH + col;
    rsp = '0;
    case (req)
      REQ_WRITE: begin
        if (in_image) begin
          shadow_pix[idx]   = val[7:0];
          shadow_known[idx] = kn;
        end
      end
      REQ_RUN: fill_image();
      REQ_READ: begin
        if (in_image) begin
          rsp.value = shadow_pix[idx];
          rsp.known = shadow_known[idx];
        end
      end
      default: ;
    endcase
    rsp.sweeps = last_sweeps;
    rsp.holes  = last_holes;
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one transaction; valid stays up across back-to-back items.
  task automatic send_req(logic [1:0] req, int col, int row, int val, bit kn);
    int    gap;
    resp_t rsp;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_pixel_col   <= col[9:0];
    in_pixel_row   <= row[8:0];
    in_write_value <= val[7:0];
    in_write_known <= kn;
    do @(posedge clk); while (!in_ready);
    predict_req(req, col, row, val, kn, rsp);
    exp_fifo[exp_wr % EXP_DEPTH] = rsp;
    exp_wr++;
    item_count++;
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Registers change only with the block idle.
  task automatic write_reg(logic [1:0] idx, int data);
    drain_block();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[10:0];
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_WIDTH) width_reg = data[10:0];
    else if (idx == CFG_HEIGHT) height_reg = data[9:0];
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_size(int w, int h);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left = 0;
    end else if (hold_req) begin
      // long hold-off so the block backs up into its input
      hold_req   = 0;
      stall_left = 400;
      out_ready  <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!idle_on) begin
      out_ready <= 1'b1;
    end else begin
      if ($urandom_range(0, 49) == 0) stall_left = $urandom_range(15, 60);
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d (item %0d)", what, got, want, item_count);
    error_count++;
  endtask

  always @(posedge clk) begin
    resp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (exp_wr == exp_rd) begin
        report_mismatch("unexpected response", 1, 0);
      end else begin
        want = exp_fifo[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (out_read_value !== want.value)
          report_mismatch("read_value", out_read_value, want.value);
        if (out_read_known !== want.known)
          report_mismatch("read_known", out_read_known, want.known);
        if (out_sweeps_done !== want.sweeps)
          report_mismatch("sweeps_done", out_sweeps_done, want.sweeps);
        if (out_holes_left !== want.holes)
          report_mismatch("holes_left", out_holes_left, want.holes);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Counters read zero before any run; default size still in force.
  task automatic test_reset_state();
    send_req(REQ_READ, 1000, 0, 0, 0);
    send_req(REQ_NONE, 5, 5, 8'hff, 1);
  endtask

  // Four-neighbor, corner pair, opposite pairs and a lone neighbor.
  task automatic test_fill_rules();
    set_size(3, 3);
    for (int y = 0; y < 3; y++)
      for (int x = 0; x < 3; x++)
        send_req(REQ_WRITE, x, y, (x == 0) ? 10 : (x == 2) ? 13 : (y == 0) ? 200 : 201,
                 (x + y) % 2 == 1);
    send_req(REQ_RUN, 0, 0, 0, 0);
    send_req(REQ_READ, 1, 1, 0, 0);
    send_req(REQ_READ, 0, 0, 0, 0);
    // left and right only
    set_size(3, 1);
    send_req(REQ_WRITE, 0, 0, 7, 1);
    send_req(REQ_WRITE, 1, 0, 0, 0);
    send_req(REQ_WRITE, 2, 0, 8, 1);
    send_req(REQ_RUN, 0, 0, 0, 0);
    send_req(REQ_READ, 1, 0, 0, 0);
    // top and bottom only
    set_size(1, 3);
    send_req(REQ_WRITE, 0, 1, 99, 0);
    send_req(REQ_WRITE, 0, 2, 254, 1);
    send_req(REQ_RUN, 0, 0, 0, 0);
    send_req(REQ_READ, 0, 1, 0, 0);
    // a single neighbor leaves the hole open
    set_size(2, 1);
    send_req(REQ_WRITE, 1, 0, 3, 0);
    send_req(REQ_RUN, 0, 0, 0, 0);
    send_req(REQ_READ, 1, 0, 0, 0);
  endtask

  // Register extremes, clamping, spare indexes and addresses off the image.
  task automatic test_size_limits();
    set_size(0, 0);
    send_req(REQ_WRITE, 0, 0, 255, 1);
    send_req(REQ_READ, 0, 0, 0, 0);
    send_req(REQ_READ, 1, 0, 0, 0);
    send_req(REQ_WRITE, 0, 1, 17, 1);
    send_req(REQ_RUN, 0, 0, 0, 0);
    write_reg(CFG_SPARE_LO, 11'h7ff);
    write_reg(CFG_SPARE_HI, 11'h555);
    set_size(11'h7ff, 10'h3ff);
    send_req(REQ_WRITE, 1023, 511, 8'h5a, 1);
    send_req(REQ_READ, 1023, 511, 0, 0);
    send_req(REQ_WRITE, 1022, 510, 8'ha5, 0);
    send_req(REQ_READ, 1022, 510, 0, 0);
    set_size(MAX_WIDTH, 1);
    send_req(REQ_WRITE, 1021, 0, 40, 1);
    send_req(REQ_WRITE, 1022, 0, 0, 0);
    send_req(REQ_WRITE, 1023, 0, 41, 1);
    send_req(REQ_RUN, 0, 0, 0, 0);
    send_req(REQ_READ, 1022, 0, 0, 0);
    send_req(REQ_READ, 1023, 511, 0, 0);
    set_size(1, MAX_HEIGHT);
    send_req(REQ_RUN, 0, 0, 0, 0);
    send_req(REQ_READ, 0, 2, 0, 0);
  endtask

  // Block fills while the response side holds off; input must stall.
  task automatic test_backpressure();
    set_size(4, 4);
    for (int i = 0; i < 16; i++)
      send_req(REQ_WRITE, i % 4, i / 4, $urandom_range(0, 255), $urandom_range(0, 1));
    drain_block();
    hold_req = 1;
    for (int i = 0; i < 12; i++)
      send_req((i % 3 == 2) ? REQ_RUN : REQ_READ, $urandom_range(0, 3), $urandom_range(0, 3),
               0, 0);
  endtask

  // Noise: unused request or an address off the active image.
  task automatic send_noise(int w, int h);
    int col, row;
    col = (w < MAX_WIDTH) ? $urandom_range(w, 1023) : $urandom_range(0, 1023);
    row = (col >= w) ? $urandom_range(0, 511) :
          (h < MAX_HEIGHT) ? $urandom_range(h, 511) : 0;
    case ($urandom_range(0, 2))
      0: send_req(REQ_NONE, $urandom_range(0, 1023), $urandom_range(0, 511),
                  $urandom_range(0, 255), $urandom_range(0, 1));
      1: send_req(REQ_WRITE, col, row, $urandom_range(0, 255), $urandom_range(0, 1));
      default: send_req(REQ_READ, (row < h) ? col : 0, row, 0, 0);
    endcase
  endtask

  // Whole scene loaded, filled, then read back; noise mixed in.
  task automatic test_random_scenes();
    int w, h, known_pct, r;
    bit narrow_vals;
    while (item_count < ITEM_TARGET) begin
      idle_on = ($urandom_range(0, 4) != 0);
      r = $urandom_range(0, 9);
      if (r == 0) begin w = $urandom_range(8, 16); h = 1; end
      else if (r == 1) begin w = 1; h = $urandom_range(8, 16); end
      else begin w = $urandom_range(1, 6); h = $urandom_range(1, 6); end
      set_size(w, h);
      known_pct   = $urandom_range(15, 85);
      narrow_vals = $urandom_range(0, 2) == 0;
      for (int y = 0; y < h; y++)
        for (int x = 0; x < w; x++) begin
          if ($urandom_range(0, 9) == 0) send_noise(w, h);
          send_req(REQ_WRITE, x, y,
                   narrow_vals ? $urandom_range(100, 103) : $urandom_range(0, 255),
                   $urandom_range(0, 99) < known_pct);
        end
      send_req(REQ_RUN, $urandom_range(0, 1023), $urandom_range(0, 511), 0, 0);
      if ($urandom_range(0, 3) == 0) send_req(REQ_RUN, 0, 0, 0, 0);
      repeat ($urandom_range(2, 6)) begin
        if ($urandom_range(0, 5) == 0) send_noise(w, h);
        send_req(REQ_READ, $urandom_range(0, w - 1), $urandom_range(0, h - 1), 0, 0);
      end
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_req_type    <= REQ_WRITE;
    in_pixel_col   <= '0;
    in_pixel_row   <= '0;
    in_write_value <= '0;
    in_write_known <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_index      <= CFG_WIDTH;
    cfg_data       <= '0;
    error_count = 0;
    item_count  = 0;
    cycle_count = 0;
    exp_wr      = 0;
    exp_rd      = 0;
    idle_on     = 1;
    hold_req    = 0;
    stall_left  = 0;
    width_reg   = 640;
    height_reg  = 480;
    last_sweeps = '0;
    last_holes  = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_fill_rules();
    test_size_limits();
    test_backpressure();
    test_random_scenes();

    drain_block();
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
